// ===== rtl/core/jetc_pkg.sv =====
// jetc_pkg: shared widths, constants, command/status structs and helper
// functions for the Julia escape-time color block.
// No dependencies; imported by every module under rtl/core.
`timescale 1ns / 1ps

package jetc_pkg;

  // Iteration number format: signed Q4.28 in 32 bits
  localparam int FRAC_BITS = 28;
  localparam int Z_W       = 32;
  localparam int ITER_BITS = 16;
  // z*z + c before saturation
  localparam int SUM_W     = 38;
  // |z|^2 sum of two shifted squares
  localparam int MAG_W     = 2 * Z_W - FRAC_BITS + 1;
  localparam logic [MAG_W-1:0] ESC_LIMIT = MAG_W'(4) << FRAC_BITS;

  // Palette arithmetic: Q.24 values
  localparam int PAL_BITS = 24;
  localparam int PAL_W    = 28;
  localparam logic signed [PAL_W-1:0] PAL_ONE  = PAL_W'(1) << PAL_BITS;
  localparam logic signed [PAL_W-1:0] PAL_K049 = PAL_W'(8220836);

  // Palette divider: floor(count * 6 * 2^24 / max_iterations)
  localparam int NUM_W      = ITER_BITS + 3 + PAL_BITS;
  localparam int Q_W        = PAL_W - 1;
  localparam int DIV_CNT_W  = $clog2(NUM_W + 1);

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_REAL = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_ADD_IMAG = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_ITER = CFG_IDX_W'(2);
  localparam logic [ITER_BITS-1:0] MAX_ITER_RST = ITER_BITS'(300);

  // Palette sequencer steps
  typedef enum logic [2:0] {
    PAL_NONE,
    PAL_RGB,
    PAL_M1,
    PAL_M2,
    PAL_M3,
    PAL_M4,
    PAL_M5
  } pal_op_t;

  typedef struct packed {
    logic    load;       // take a new starting point, clear iteration index
    logic    cnt_max;    // count := max_iterations
    logic    cnt_iter;   // count := current iteration index
    logic    sqr;        // register zr^2, zi^2, zr*zi
    logic    upd;        // z := z^2 + c
    logic    iter_inc;   // advance iteration index
    logic    div_start;  // launch palette divider
    pal_op_t pal_op;     // palette datapath step
    logic    out_load;   // load result register
  } jetc_cmd_t;

  typedef struct packed {
    logic max_zero;  // max_iterations == 0
    logic escape;    // |z|^2 > 4 on current squares
    logic last;      // iteration index + 1 == max_iterations
    logic div_busy;
  } jetc_stat_t;

  function automatic logic signed [Z_W-1:0] sat_z(input logic signed [SUM_W-1:0] v);
    localparam logic signed [SUM_W-1:0] ZMAX = SUM_W'((64'sd1 <<< (Z_W - 1)) - 1);
    localparam logic signed [SUM_W-1:0] ZMIN = -SUM_W'(64'sd1 <<< (Z_W - 1));
    if (v > ZMAX) begin
      return ZMAX[Z_W-1:0];
    end else if (v < ZMIN) begin
      return ZMIN[Z_W-1:0];
    end
    return v[Z_W-1:0];
  endfunction

  function automatic logic signed [PAL_W-1:0] abs_pal(input logic signed [PAL_W-1:0] v);
    return (v < 0) ? -v : v;
  endfunction

  // Clamp to [0, 1] then floor(v * 255)
  function automatic logic [7:0] to_chan(input logic signed [PAL_W-1:0] v);
    logic [PAL_BITS:0]   vc;
    logic [PAL_BITS+8:0] prod;
    if (v < 0) begin
      vc = '0;
    end else if (v > PAL_ONE) begin
      vc = PAL_ONE[PAL_BITS:0];
    end else begin
      vc = v[PAL_BITS:0];
    end
    prod = {vc, 8'b0} - {8'b0, vc};
    return prod[PAL_BITS+7:PAL_BITS];
  endfunction

endpackage

// ===== rtl/core/jetc_div.sv =====
// jetc_div: restoring divider for the palette position, one quotient bit
// per cycle. Depends on jetc_pkg.
`timescale 1ns / 1ps

module jetc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [jetc_pkg::ITER_BITS-1:0]    dividend,
  input  logic [jetc_pkg::ITER_BITS-1:0]    divisor,
  output logic                              busy,
  output logic [jetc_pkg::Q_W-1:0]          quot
);
  import jetc_pkg::*;

  localparam int N6_W = ITER_BITS + 3;

  logic [NUM_W-1:0]     num_r;
  logic [ITER_BITS-1:0] rem_r;
  logic [Q_W-1:0]       q_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;

  logic [N6_W-1:0]      times6;
  logic [ITER_BITS:0]   rem_sh;
  logic                 ge;
  logic [ITER_BITS-1:0] rem_nxt;

  assign times6  = (N6_W'(dividend) << 2) + (N6_W'(dividend) << 1);
  assign rem_sh  = {rem_r, num_r[NUM_W-1]};
  assign ge      = rem_sh >= {1'b0, divisor};
  assign rem_nxt = ge ? ITER_BITS'(rem_sh - {1'b0, divisor}) : rem_sh[ITER_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= DIV_CNT_W'(NUM_W);
    end else if (busy_r) begin
      cnt_r <= cnt_r - 1'b1;
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // Quotient never exceeds Q_W bits since dividend <= divisor
  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= {times6, PAL_BITS'(0)};
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      num_r <= {num_r[NUM_W-2:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= {q_r[Q_W-2:0], ge};
    end
  end

  assign busy = busy_r;
  assign quot = q_r;

endmodule

// ===== rtl/core/jetc_dp.sv =====
// jetc_dp: configuration registers, z iteration datapath, palette
// multiplier chain and result register. Depends on jetc_pkg, jetc_div.
`timescale 1ns / 1ps

module jetc_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [jetc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [31:0]                          cfg_data,
  input  logic signed [jetc_pkg::Z_W-1:0]      start_real,
  input  logic signed [jetc_pkg::Z_W-1:0]      start_imag,
  input  jetc_pkg::jetc_cmd_t                  cmd,
  output jetc_pkg::jetc_stat_t                 stat,
  output logic [jetc_pkg::ITER_BITS-1:0]       iteration_count,
  output logic [7:0]                           red,
  output logic [7:0]                           green,
  output logic [7:0]                           blue
);
  import jetc_pkg::*;

  localparam int PW = 2 * Z_W;
  localparam int MW = 2 * PAL_W;
  localparam logic signed [PAL_W-1:0] PAL_TWO   = PAL_W'(2) * PAL_ONE;
  localparam logic signed [PAL_W-1:0] PAL_THREE = PAL_W'(3) * PAL_ONE;
  localparam logic signed [PAL_W-1:0] PAL_FOUR  = PAL_W'(4) * PAL_ONE;

  // configuration
  logic signed [Z_W-1:0]  add_real_r;
  logic signed [Z_W-1:0]  add_imag_r;
  logic [ITER_BITS-1:0]   max_iter_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      add_real_r <= '0;
      add_imag_r <= '0;
      max_iter_r <= MAX_ITER_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ADD_REAL: add_real_r <= cfg_data;
        CFG_ADD_IMAG: add_imag_r <= cfg_data;
        CFG_MAX_ITER: max_iter_r <= cfg_data[ITER_BITS-1:0];
        default: ;
      endcase
    end
  end

  // iteration
  logic signed [Z_W-1:0]  zr_r, zi_r;
  logic signed [PW-1:0]   xx_r, yy_r, xy_r;
  logic [ITER_BITS-1:0]   iter_r;
  logic [ITER_BITS-1:0]   count_r;

  logic signed [PW-1:0]    xx_c, yy_c, xy_c, diff;
  logic signed [SUM_W-1:0] nr_sum, ni_sum;
  logic [MAG_W-1:0]        mag;

  assign xx_c   = zr_r * zr_r;
  assign yy_c   = zi_r * zi_r;
  assign xy_c   = zr_r * zi_r;
  assign diff   = xx_r - yy_r;
  assign nr_sum = SUM_W'(diff >>> FRAC_BITS) + SUM_W'(add_real_r);
  assign ni_sum = SUM_W'(xy_r >>> (FRAC_BITS - 1)) + SUM_W'(add_imag_r);
  // squares are non-negative, so the shifted high parts are plain unsigned
  assign mag    = {1'b0, xx_r[PW-1:FRAC_BITS]} + {1'b0, yy_r[PW-1:FRAC_BITS]};

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      zr_r <= start_real;
      zi_r <= start_imag;
    end else if (cmd.upd) begin
      zr_r <= sat_z(nr_sum);
      zi_r <= sat_z(ni_sum);
    end
    if (cmd.sqr) begin
      xx_r <= xx_c;
      yy_r <= yy_c;
      xy_r <= xy_c;
    end
    if (cmd.cnt_max) begin
      count_r <= max_iter_r;
    end else if (cmd.cnt_iter) begin
      count_r <= iter_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iter_r <= '0;
    end else if (cmd.load) begin
      iter_r <= '0;
    end else if (cmd.iter_inc) begin
      iter_r <= iter_r + 1'b1;
    end
  end

  assign stat.max_zero = (max_iter_r == '0);
  assign stat.escape   = (mag > ESC_LIMIT);
  assign stat.last     = ({1'b0, iter_r} + 1'b1) == {1'b0, max_iter_r};

  // palette position
  logic [Q_W-1:0] quot;
  logic           div_busy;

  jetc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (count_r),
    .divisor  (max_iter_r),
    .busy     (div_busy),
    .quot     (quot)
  );

  assign stat.div_busy = div_busy;

  // palette chain through one shared multiplier
  logic signed [PAL_W-1:0] t_c;
  logic signed [PAL_W-1:0] r_r, g_r, b_r, rs_r, gs_r, k2_r;
  logic signed [MW-1:0]    p_r;
  logic signed [PAL_W-1:0] p_sh, k_c, mul_a, mul_b;

  assign t_c  = stat.max_zero ? '0 : $signed({1'b0, quot});
  assign p_sh = PAL_W'(p_r >>> PAL_BITS);
  assign k_c  = PAL_ONE - p_sh;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (cmd.pal_op)
      PAL_M1: begin
        mul_a = r_r;
        mul_b = PAL_K049;
      end
      PAL_M2: begin
        mul_a = r_r;
        mul_b = k_c;
      end
      PAL_M3: begin
        mul_a = p_sh;
        mul_b = PAL_K049;
      end
      PAL_M4: begin
        mul_a = g_r;
        mul_b = k_c;
      end
      PAL_M5: begin
        mul_a = b_r;
        mul_b = k2_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.pal_op) inside
      PAL_RGB: begin
        r_r <= abs_pal(t_c - PAL_THREE) - PAL_ONE;
        g_r <= PAL_TWO - abs_pal(t_c - PAL_TWO);
        b_r <= PAL_TWO - abs_pal(t_c - PAL_FOUR);
      end
      PAL_M1, PAL_M2: p_r <= mul_a * mul_b;
      PAL_M3: begin
        rs_r <= p_sh;
        p_r  <= mul_a * mul_b;
      end
      PAL_M4: begin
        k2_r <= k_c;
        p_r  <= mul_a * mul_b;
      end
      PAL_M5: begin
        gs_r <= p_sh;
        p_r  <= mul_a * mul_b;
      end
      default: ;
    endcase
  end

  // result register; p_r holds b * k2 at load time
  logic [ITER_BITS-1:0] cnt_out_r;
  logic [7:0]           red_r, green_r, blue_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_out_r <= '0;
      red_r     <= '0;
      green_r   <= '0;
      blue_r    <= '0;
    end else if (cmd.out_load) begin
      cnt_out_r <= count_r;
      red_r     <= to_chan(rs_r);
      green_r   <= to_chan(gs_r);
      blue_r    <= to_chan(p_sh);
    end
  end

  assign iteration_count = cnt_out_r;
  assign red             = red_r;
  assign green           = green_r;
  assign blue            = blue_r;

endmodule

// ===== rtl/core/jetc_ctrl.sv =====
// jetc_ctrl: sequencer for iteration, palette division and palette steps,
// plus input/output handshake control. Depends on jetc_pkg.
`timescale 1ns / 1ps

module jetc_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  jetc_pkg::jetc_stat_t  stat,
  output jetc_pkg::jetc_cmd_t   cmd
);
  import jetc_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_STEP,
    S_DIV_GO,
    S_DIV,
    S_PAL,
    S_OUT
  } state_t;

  state_t  state_r, state_nxt;
  logic    first_r, first_nxt;
  pal_op_t op_r, op_nxt;
  logic    out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    first_nxt     = first_r;
    op_nxt        = op_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    cmd.pal_op    = PAL_NONE;

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.max_zero) begin
            cmd.cnt_max = 1'b1;
            state_nxt   = S_DIV_GO;
          end else begin
            first_nxt = 1'b1;
            state_nxt = S_SQR;
          end
        end
      end
      S_SQR: begin
        cmd.sqr   = 1'b1;
        state_nxt = S_STEP;
      end
      S_STEP: begin
        if (first_r) begin
          // starting point itself is not tested
          cmd.upd   = 1'b1;
          first_nxt = 1'b0;
          state_nxt = S_SQR;
        end else if (stat.escape) begin
          cmd.cnt_iter = 1'b1;
          state_nxt    = S_DIV_GO;
        end else if (stat.last) begin
          cmd.cnt_max = 1'b1;
          state_nxt   = S_DIV_GO;
        end else begin
          cmd.upd      = 1'b1;
          cmd.iter_inc = 1'b1;
          state_nxt    = S_SQR;
        end
      end
      S_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = S_DIV;
      end
      S_DIV: begin
        if (!stat.div_busy) begin
          op_nxt    = PAL_RGB;
          state_nxt = S_PAL;
        end
      end
      S_PAL: begin
        cmd.pal_op = op_r;
        unique case (op_r)
          PAL_RGB: op_nxt = PAL_M1;
          PAL_M1:  op_nxt = PAL_M2;
          PAL_M2:  op_nxt = PAL_M3;
          PAL_M3:  op_nxt = PAL_M4;
          PAL_M4:  op_nxt = PAL_M5;
          PAL_M5: begin
            op_nxt    = PAL_NONE;
            state_nxt = S_OUT;
          end
          default: begin
            op_nxt    = PAL_NONE;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      first_r     <= 1'b0;
      op_r        <= PAL_NONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      first_r     <= first_nxt;
      op_r        <= op_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/core/julia_escape_time_color.sv =====
// julia_escape_time_color: top level, stream ports and configuration port.
// Depends on jetc_pkg, jetc_ctrl, jetc_dp (which holds jetc_div).
`timescale 1ns / 1ps

// One request on the input stream is a starting point z in signed Q4.28. The
// block iterates z = z*z + c (c from add_to_real / add_to_imag), stopping at
// the first update that leaves |z|^2 > 4 or after max_iterations updates, and
// returns the iteration count with an RGB palette color. One point is worked
// at a time: the input is ready only while the block is idle, but a finished
// result may sit in the output register while the next point is taken. A
// point passes, in order, through the idle state that takes the request, a
// square step and then an update-and-escape-test step for each update, one
// more square-and-test pair that ends the loop, the bit-serial palette
// divider (launch, 43 quotient bits, done check), six palette steps and the
// output load. A zero limit skips the loop. The output load waits while the
// previous result is still held by the receiver. The default limit is 300.
// Overflowing parts saturate to 32 bits, so such points escape.
// Configuration writes are always accepted (cfg_ready is tied high) and must
// only be issued while no point is in flight.

module julia_escape_time_color (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,  // 0 add_to_real, 1 add_to_imag, 2 max_iterations
  input  logic [31:0] cfg_data,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] start_real, [63:32] start_imag
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [15:0] iteration_count, [23:16] red,
                                  // [31:24] green, [39:32] blue
);
  import jetc_pkg::*;

  jetc_cmd_t            cmd;
  jetc_stat_t           stat;
  logic [ITER_BITS-1:0] iteration_count;
  logic [7:0]           red, green, blue;

  assign cfg_ready = 1'b1;

  jetc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  jetc_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .start_real      (in_tdata[31:0]),
    .start_imag      (in_tdata[63:32]),
    .cmd             (cmd),
    .stat            (stat),
    .iteration_count (iteration_count),
    .red             (red),
    .green           (green),
    .blue            (blue)
  );

  assign out_tdata = {blue, green, red, iteration_count};

  // one point in flight: accepting a request drops ready
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("input accepted while a point is in flight");

  // a new result appears exactly when the block returns to idle
  a_result_frees_input: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $rose(in_tready))
    else $error("result raised without returning to idle");

  // accepting a point never disturbs the waiting result
  a_result_held_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> $stable(out_tdata))
    else $error("result register changed on input accept");

endmodule
